[rtl/core/bmvc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum line cover package
// Shared widths, controller states, command/status bundles and bit helpers.
// ----------------------------------------------------------------------------
package bmvc_pkg;

    localparam int unsigned MAX_N_DEF = 64;
    localparam int unsigned VEC_W     = 64;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned CNT_W     = 7;

    typedef logic [VEC_W-1:0] vec_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SOLVE_INIT,
        ST_BFS_INIT,
        ST_PICK,
        ST_ROW_DATA,
        ST_COL_STEP,
        ST_PARTNER_DATA,
        ST_AUG_READ,
        ST_AUG_WRITE,
        ST_AUG_PARENT,
        ST_OUT_INIT,
        ST_OUT_RUN
    } state_t;

    typedef struct packed {
        logic load_row;
        logic solve_init;
        logic bfs_init;
        logic pick;
        logic latch_cand;
        logic col_step;
        logic take_partner;
        logic aug_read;
        logic aug_write;
        logic aug_parent;
        logic aug_finish;
        logic out_init;
        logic out_emit;
    } cmd_t;

    typedef struct packed {
        logic grid_full;
        logic pending_any;
        logic cand_any;
        logic col_matched;
        logic row_matched;
        logic out_slot_free;
        logic out_last;
        cnt_t match_cnt;
        vec_t row_has;
    } status_t;

    // Index of the lowest set bit; zero when none is set.
    function automatic idx_t lowest_one(input vec_t v);
        idx_t r;
        r = '0;
        for (int i = VEC_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    // True when at most one bit is set.
    function automatic logic at_most_one(input vec_t v);
        return (v & (v - vec_t'(1))) == '0;
    endfunction

endpackage

[rtl/core/bmvc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmvc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/bmvc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum line cover controller
// Sequences loading, augmenting search, reach marking and result output.
// ----------------------------------------------------------------------------
module bmvc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bmvc_pkg::status_t status,
    output bmvc_pkg::cmd_t    cmd
);

    bmvc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmvc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            bmvc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_row = 1'b1;
                    if (status.grid_full) begin
                        state_next = bmvc_pkg::ST_SOLVE_INIT;
                    end
                end
            end
            bmvc_pkg::ST_SOLVE_INIT: begin
                cmd.solve_init = 1'b1;
                state_next     = bmvc_pkg::ST_BFS_INIT;
            end
            bmvc_pkg::ST_BFS_INIT: begin
                cmd.bfs_init = 1'b1;
                state_next   = bmvc_pkg::ST_PICK;
            end
            bmvc_pkg::ST_PICK: begin
                if (status.pending_any) begin
                    cmd.pick   = 1'b1;
                    state_next = bmvc_pkg::ST_ROW_DATA;
                end else begin
                    state_next = bmvc_pkg::ST_OUT_INIT;
                end
            end
            bmvc_pkg::ST_ROW_DATA: begin
                cmd.latch_cand = 1'b1;
                state_next     = bmvc_pkg::ST_COL_STEP;
            end
            bmvc_pkg::ST_COL_STEP: begin
                if (status.cand_any) begin
                    cmd.col_step = 1'b1;
                    state_next   = status.col_matched ? bmvc_pkg::ST_PARTNER_DATA
                                                      : bmvc_pkg::ST_AUG_READ;
                end else begin
                    state_next = bmvc_pkg::ST_PICK;
                end
            end
            bmvc_pkg::ST_PARTNER_DATA: begin
                cmd.take_partner = 1'b1;
                state_next       = bmvc_pkg::ST_COL_STEP;
            end
            bmvc_pkg::ST_AUG_READ: begin
                if (status.row_matched) begin
                    cmd.aug_read = 1'b1;
                    state_next   = bmvc_pkg::ST_AUG_WRITE;
                end else begin
                    cmd.aug_finish = 1'b1;
                    state_next     = bmvc_pkg::ST_BFS_INIT;
                end
            end
            bmvc_pkg::ST_AUG_WRITE: begin
                cmd.aug_write = 1'b1;
                state_next    = bmvc_pkg::ST_AUG_PARENT;
            end
            bmvc_pkg::ST_AUG_PARENT: begin
                cmd.aug_parent = 1'b1;
                state_next     = bmvc_pkg::ST_AUG_READ;
            end
            bmvc_pkg::ST_OUT_INIT: begin
                cmd.out_init = 1'b1;
                state_next   = bmvc_pkg::ST_OUT_RUN;
            end
            bmvc_pkg::ST_OUT_RUN: begin
                if (status.out_slot_free) begin
                    cmd.out_emit = 1'b1;
                    if (status.out_last) begin
                        state_next = bmvc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = bmvc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/bmvc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum line cover datapath
// Grid and partner memories, reach vectors, augmenting walk and output stage.
// ----------------------------------------------------------------------------
module bmvc_datapath #(
    parameter int unsigned MAX_N = bmvc_pkg::MAX_N_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [bmvc_pkg::CNT_W-1:0]  cfg_wr_data,
    input  logic [bmvc_pkg::VEC_W-1:0]  s_row_cells,
    input  bmvc_pkg::cmd_t              cmd,
    output bmvc_pkg::status_t           status,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic [bmvc_pkg::CNT_W-1:0]  m_match_count,
    output logic                        m_line_kind,
    output logic [bmvc_pkg::CNT_W-1:0]  m_line_index,
    output logic                        m_line_valid,
    output logic                        m_last
);

    localparam int unsigned AW = $clog2(MAX_N);

    bmvc_pkg::cnt_t grid_size_reg, rows_loaded_reg, count_reg;
    bmvc_pkg::vec_t row_reached_reg, col_reached_reg, row_done_reg;
    bmvc_pkg::vec_t row_has_reg, col_has_reg, cand_reg, rem_r_reg, rem_c_reg;
    bmvc_pkg::idx_t r_cur_reg, c_cur_reg, p_cur_reg;

    logic           m_valid_reg, m_kind_reg, m_lvalid_reg, m_last_reg;
    bmvc_pkg::cnt_t m_count_reg, m_index_reg;

    bmvc_pkg::cnt_t n_eff;
    bmvc_pkg::vec_t nmask, pend;
    bmvc_pkg::idx_t pend_idx, cand_idx, rowp_rd, colp_rd, colpar_rd;
    bmvc_pkg::vec_t grid_rd;
    logic           pair_we, out_last;

    always_comb begin
        if (grid_size_reg == '0) begin
            n_eff = bmvc_pkg::CNT_W'(1);
        end else if (grid_size_reg > bmvc_pkg::CNT_W'(MAX_N)) begin
            n_eff = bmvc_pkg::CNT_W'(MAX_N);
        end else begin
            n_eff = grid_size_reg;
        end
        for (int i = 0; i < bmvc_pkg::VEC_W; i++) begin
            nmask[i] = bmvc_pkg::CNT_W'(i) < n_eff;
        end
    end

    assign pend     = row_reached_reg & ~row_done_reg;
    assign pend_idx = bmvc_pkg::lowest_one(pend);
    assign cand_idx = bmvc_pkg::lowest_one(cand_reg);
    assign pair_we  = cmd.aug_write | cmd.aug_finish;

    bmvc_ram #(.WIDTH(bmvc_pkg::VEC_W), .DEPTH(MAX_N)) u_grid (
        .aclk    (aclk),
        .wr_en   (cmd.load_row),
        .wr_addr (rows_loaded_reg[AW-1:0]),
        .wr_data (s_row_cells),
        .rd_addr (pend_idx[AW-1:0]),
        .rd_data (grid_rd)
    );

    bmvc_ram #(.WIDTH(bmvc_pkg::IDX_W), .DEPTH(MAX_N)) u_row_partner (
        .aclk    (aclk),
        .wr_en   (pair_we),
        .wr_addr (r_cur_reg[AW-1:0]),
        .wr_data (c_cur_reg),
        .rd_addr (r_cur_reg[AW-1:0]),
        .rd_data (rowp_rd)
    );

    bmvc_ram #(.WIDTH(bmvc_pkg::IDX_W), .DEPTH(MAX_N)) u_col_partner (
        .aclk    (aclk),
        .wr_en   (pair_we),
        .wr_addr (c_cur_reg[AW-1:0]),
        .wr_data (r_cur_reg),
        .rd_addr (cand_idx[AW-1:0]),
        .rd_data (colp_rd)
    );

    // Row that first reached each column in the current search.
    bmvc_ram #(.WIDTH(bmvc_pkg::IDX_W), .DEPTH(MAX_N)) u_col_parent (
        .aclk    (aclk),
        .wr_en   (cmd.col_step),
        .wr_addr (cand_idx[AW-1:0]),
        .wr_data (r_cur_reg),
        .rd_addr (rowp_rd[AW-1:0]),
        .rd_data (colpar_rd)
    );

    always_comb begin
        if (rem_r_reg != '0) begin
            out_last = bmvc_pkg::at_most_one(rem_r_reg) && (rem_c_reg == '0);
        end else begin
            out_last = bmvc_pkg::at_most_one(rem_c_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg   <= bmvc_pkg::CNT_W'(64);
            rows_loaded_reg <= '0;
            count_reg       <= '0;
            row_has_reg     <= '0;
            col_has_reg     <= '0;
            row_reached_reg <= '0;
            col_reached_reg <= '0;
            row_done_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                grid_size_reg <= cfg_wr_data;
            end
            if (cmd.load_row) begin
                rows_loaded_reg <= status.grid_full ? '0 : rows_loaded_reg + 1'b1;
            end
            if (cmd.solve_init) begin
                count_reg   <= '0;
                row_has_reg <= '0;
                col_has_reg <= '0;
            end
            if (cmd.bfs_init) begin
                row_reached_reg <= ~row_has_reg & nmask;
                col_reached_reg <= '0;
                row_done_reg    <= '0;
            end
            if (cmd.pick) begin
                row_done_reg <= row_done_reg | (bmvc_pkg::vec_t'(1) << pend_idx);
            end
            if (cmd.col_step) begin
                col_reached_reg <= col_reached_reg | (bmvc_pkg::vec_t'(1) << cand_idx);
            end
            if (cmd.take_partner) begin
                row_reached_reg <= row_reached_reg | (bmvc_pkg::vec_t'(1) << colp_rd);
            end
            if (pair_we) begin
                col_has_reg <= col_has_reg | (bmvc_pkg::vec_t'(1) << c_cur_reg);
            end
            if (cmd.aug_finish) begin
                row_has_reg <= row_has_reg | (bmvc_pkg::vec_t'(1) << r_cur_reg);
                count_reg   <= count_reg + 1'b1;
            end
            if (cmd.out_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pick) begin
            r_cur_reg <= pend_idx;
        end
        if (cmd.latch_cand) begin
            cand_reg <= grid_rd & nmask & ~col_reached_reg;
        end
        if (cmd.col_step) begin
            cand_reg  <= cand_reg & ~(bmvc_pkg::vec_t'(1) << cand_idx);
            c_cur_reg <= cand_idx;
        end
        if (cmd.aug_write) begin
            p_cur_reg <= rowp_rd;
        end
        if (cmd.aug_parent) begin
            r_cur_reg <= colpar_rd;
            c_cur_reg <= p_cur_reg;
        end
        if (cmd.out_init) begin
            rem_r_reg <= ~row_reached_reg & nmask;
            rem_c_reg <= col_reached_reg;
        end
        if (cmd.out_emit) begin
            m_count_reg <= count_reg;
            m_last_reg  <= out_last;
            if (rem_r_reg != '0) begin
                rem_r_reg    <= rem_r_reg & ~(bmvc_pkg::vec_t'(1) << bmvc_pkg::lowest_one(rem_r_reg));
                m_kind_reg   <= 1'b0;
                m_index_reg  <= bmvc_pkg::CNT_W'(bmvc_pkg::lowest_one(rem_r_reg)) + 1'b1;
                m_lvalid_reg <= 1'b1;
            end else if (rem_c_reg != '0) begin
                rem_c_reg    <= rem_c_reg & ~(bmvc_pkg::vec_t'(1) << bmvc_pkg::lowest_one(rem_c_reg));
                m_kind_reg   <= 1'b1;
                m_index_reg  <= bmvc_pkg::CNT_W'(bmvc_pkg::lowest_one(rem_c_reg)) + 1'b1;
                m_lvalid_reg <= 1'b1;
            end else begin
                m_kind_reg   <= 1'b0;
                m_index_reg  <= '0;
                m_lvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        status               = '0;
        status.grid_full     = (rows_loaded_reg + 1'b1) >= n_eff;
        status.pending_any   = pend != '0;
        status.cand_any      = cand_reg != '0;
        status.col_matched   = col_has_reg[cand_idx];
        status.row_matched   = row_has_reg[r_cur_reg];
        status.out_slot_free = !m_valid_reg || m_ready;
        status.out_last      = out_last;
        status.match_cnt     = count_reg;
        status.row_has       = row_has_reg;
    end

    assign m_valid       = m_valid_reg;
    assign m_match_count = m_count_reg;
    assign m_line_kind   = m_kind_reg;
    assign m_line_index  = m_index_reg;
    assign m_line_valid  = m_lvalid_reg;
    assign m_last        = m_last_reg;

endmodule

[rtl/core/bipartite_matching_vertex_cover.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum line cover of a coin grid
// Loads an n-by-n grid one row per item, finds a maximum matching of rows to
// columns by augmenting search, and emits the Konig vertex cover.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    row_cells (64 bits)
//  m_        out        m_valid / m_ready    match_count, line_kind, line_index,
//                                            line_valid, last
//  cfg_      in         cfg_wr_en            grid_size (7 bits)
//
// After row n the solver runs a breadth first search from all unmatched
// rows and applies each augmenting path that it finds. There are at most
// n + 1 searches. Results then leave at one per cycle while m_ready is
// high, through a registered output stage.
// Reset is synchronous and active low; the memories need no clearing pass.
// No row is accepted while a grid is being solved or its results emitted.
// ----------------------------------------------------------------------------
module bipartite_matching_vertex_cover #(
    parameter int unsigned MAX_N = bmvc_pkg::MAX_N_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [bmvc_pkg::CNT_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bmvc_pkg::VEC_W-1:0]  s_row_cells,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bmvc_pkg::CNT_W-1:0]  m_match_count,
    output logic                        m_line_kind,
    output logic [bmvc_pkg::CNT_W-1:0]  m_line_index,
    output logic                        m_line_valid,
    output logic                        m_last
);

    bmvc_pkg::cmd_t    cmd;
    bmvc_pkg::status_t status;

    // The controller only sequences; all data storage sits in the datapath.
    bmvc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bmvc_datapath #(.MAX_N(MAX_N)) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_row_cells   (s_row_cells),
        .cmd           (cmd),
        .status        (status),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_match_count (m_match_count),
        .m_line_kind   (m_line_kind),
        .m_line_index  (m_line_index),
        .m_line_valid  (m_line_valid),
        .m_last        (m_last)
    );

    // Every matched row accounts for exactly one unit of the matching size.
    a_count_matches_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(status.row_has) == status.match_cnt)
        else $error("matching size disagrees with matched rows");

    // An empty cover result is always the final one of its grid.
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_line_valid) |-> m_last)
        else $error("empty cover result without last");

    // A named line always carries a 1-based index.
    a_index_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_line_valid) |-> (m_line_index != '0))
        else $error("cover line with zero index");

endmodule

[verif/bmvc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line cover checker
// Watches the row, result and register ports, predicts the minimum line cover
// of each completed grid and compares every result item in order.
// ----------------------------------------------------------------------------
module bmvc_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [bmvc_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [bmvc_pkg::VEC_W-1:0] s_row_cells,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [bmvc_pkg::CNT_W-1:0] m_match_count,
    input  logic                       m_line_kind,
    input  logic [bmvc_pkg::CNT_W-1:0] m_line_index,
    input  logic                       m_line_valid,
    input  logic                       m_last,
    output int                         fail_count,
    output int                         pending_count
);

    typedef struct {
        bmvc_pkg::cnt_t match_count;
        logic           line_kind;
        bmvc_pkg::cnt_t line_index;
        logic           line_valid;
        logic           last;
    } cover_line_t;

    cover_line_t    cover_q[$];
    bmvc_pkg::vec_t grid_mem [64];
    bmvc_pkg::cnt_t size_reg;
    int             rows_in;
    int             row_mate [64];
    int             col_mate [64];

    function automatic int unsigned clamp_size(input bmvc_pkg::cnt_t v);
        if (v == 0) return 1;
        if (v > 64) return 64;
        return 32'(v);
    endfunction

    // Kuhn matching with one breadth first search per row, then the
    // alternating reach from unmatched rows; the cover is the same set
    // for every maximum matching.
    task automatic predict_cover(input int unsigned n);
        int             col_from [64];
        bit             col_seen [64];
        int             row_fifo [$];
        int             found, r, c, nxt, total;
        bmvc_pkg::vec_t row_reach, col_reach;
        cover_line_t    line;
        bit             any;
        for (int i = 0; i < 64; i++) begin
            row_mate[i] = -1;
            col_mate[i] = -1;
        end
        total = 0;
        for (int root = 0; root < n; root++) begin
            for (int j = 0; j < 64; j++) col_seen[j] = 0;
            row_fifo = {root};
            found = -1;
            while (row_fifo.size() != 0 && found < 0) begin
                r = row_fifo.pop_front();
                for (int j = 0; j < n && found < 0; j++) begin
                    if (grid_mem[r][j] && !col_seen[j]) begin
                        col_seen[j] = 1;
                        col_from[j] = r;
                        if (col_mate[j] < 0) found = j;
                        else row_fifo = {row_fifo, col_mate[j]};
                    end
                end
            end
            if (found >= 0) begin
                total++;
                c = found;
                while (c >= 0) begin
                    r = col_from[c];
                    nxt = row_mate[r];
                    row_mate[r] = c;
                    col_mate[c] = r;
                    c = nxt;
                end
            end
        end
        row_reach = '0;
        col_reach = '0;
        row_fifo = {};
        for (int i = 0; i < n; i++) begin
            if (row_mate[i] < 0) begin
                row_reach[i] = 1'b1;
                row_fifo = {row_fifo, i};
            end
        end
        while (row_fifo.size() != 0) begin
            r = row_fifo.pop_front();
            for (int j = 0; j < n; j++) begin
                if (grid_mem[r][j] && !col_reach[j]) begin
                    col_reach[j] = 1'b1;
                    if (col_mate[j] >= 0 && !row_reach[col_mate[j]]) begin
                        row_reach[col_mate[j]] = 1'b1;
                        row_fifo = {row_fifo, col_mate[j]};
                    end
                end
            end
        end
        any = 0;
        for (int t = 0; t < 2; t++) begin
            for (int i = 0; i < n; i++) begin
                if ((t == 0) ? !row_reach[i] : col_reach[i]) begin
                    line.match_count = bmvc_pkg::cnt_t'(total);
                    line.line_kind   = t[0];
                    line.line_index  = bmvc_pkg::cnt_t'(i + 1);
                    line.line_valid  = 1'b1;
                    line.last        = 1'b0;
                    cover_q = {cover_q, line};
                    any = 1;
                end
            end
        end
        if (any) begin
            cover_q[cover_q.size() - 1].last = 1'b1;
        end else begin
            line.match_count = bmvc_pkg::cnt_t'(total);
            line.line_kind   = 1'b0;
            line.line_index  = '0;
            line.line_valid  = 1'b0;
            line.last        = 1'b1;
            cover_q = {cover_q, line};
        end
    endtask

    always @(posedge aclk) begin
        cover_line_t want;
        int unsigned n;
        if (!aresetn) begin
            size_reg   <= bmvc_pkg::cnt_t'(64);
            rows_in    = 0;
            fail_count <= 0;
            cover_q    = {};
        end else begin
            if (cfg_wr_en) size_reg <= cfg_wr_data;
            if (s_valid && s_ready) begin
                n = clamp_size(size_reg);
                if (rows_in < 64) grid_mem[rows_in] = s_row_cells;
                rows_in++;
                if (rows_in >= n) begin
                    rows_in = 0;
                    predict_cover(n);
                end
            end
            if (m_valid && m_ready) begin
                if (cover_q.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    want = cover_q.pop_front();
                    if (m_match_count !== want.match_count ||
                        m_line_kind !== want.line_kind ||
                        m_line_index !== want.line_index ||
                        m_line_valid !== want.line_valid || m_last !== want.last)
                        fail_count <= fail_count + 1;
                    if (m_match_count !== want.match_count)
                        $error("match_count expected %0d got %0d",
                               want.match_count, m_match_count);
                    if (m_line_kind !== want.line_kind)
                        $error("line_kind expected %0d got %0d",
                               want.line_kind, m_line_kind);
                    if (m_line_index !== want.line_index)
                        $error("line_index expected %0d got %0d",
                               want.line_index, m_line_index);
                    if (m_line_valid !== want.line_valid)
                        $error("line_valid expected %0d got %0d",
                               want.line_valid, m_line_valid);
                    if (m_last !== want.last)
                        $error("last expected %0d got %0d", want.last, m_last);
                end
            end
        end
        pending_count = cover_q.size();
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line cover block testbench
// Loads coin grids of many sizes, lets the checker predict each cover and
// compare the result items, and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_HOLD      = 300;

    logic           aclk;
    logic           aresetn;
    logic           cfg_wr_en;
    bmvc_pkg::cnt_t cfg_wr_data;
    logic           s_valid;
    logic           s_ready;
    bmvc_pkg::vec_t s_row_cells;
    logic           m_valid;
    logic           m_ready;
    bmvc_pkg::cnt_t m_match_count;
    logic           m_line_kind;
    bmvc_pkg::cnt_t m_line_index;
    logic           m_line_valid;
    logic           m_last;
    int             fail_count;
    int             pending_count;

    // Stimulus bookkeeping, shared with the receiver and the watchdog.
    bit          quiet;
    bit          hold_req;
    int          rows_sent;
    int          grids_sent;
    int          lines_seen;
    int          idle_cycles;

    bipartite_matching_vertex_cover u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_row_cells(s_row_cells),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_match_count(m_match_count), .m_line_kind(m_line_kind),
        .m_line_index(m_line_index), .m_line_valid(m_line_valid),
        .m_last(m_last)
    );

    bmvc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_row_cells(s_row_cells),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_match_count(m_match_count), .m_line_kind(m_line_kind),
        .m_line_index(m_line_index), .m_line_valid(m_line_valid),
        .m_last(m_last),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stall bursts, one long hold-off once a grid is being
    // emitted, and an always-ready stretch at the end of the run.
    initial begin
        int burst;
        int hold;
        bit held;
        burst = 0;
        hold  = 0;
        held  = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (hold_req && !held && m_valid) begin
                // The block keeps its result pending while rows queue up on
                // the input side, so the sender is stalled too.
                held = 1;
                hold = LONG_HOLD;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 9) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog and accounting of handshakes, sampled at the rising edge.
    initial begin
        idle_cycles = 0;
        lines_seen  = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) lines_seen++;
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d cycles without a handshake", idle_cycles);
                $display("bipartite_matching_vertex_cover verification failed");
                $finish;
            end
        end
    end

    // Offers one row item; entered and left at a falling edge. A random gap
    // may come first unless the run is in its quiet part.
    task automatic send_row(input bmvc_pkg::vec_t cells);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_row_cells <= cells;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rows_sent++;
        @(negedge aclk);
    endtask

    // Lets every expected result arrive, then waits out DRAIN_CYCLES in case a
    // grid is still being worked on, so that the register may be written.
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_size(input bmvc_pkg::cnt_t value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random row with a density picked per row: sparse rows leave rows
    // unmatched and give long alternating paths, dense rows give full
    // matchings, single coins give permutation-like grids.
    function automatic bmvc_pkg::vec_t random_row(input int unsigned n);
        bmvc_pkg::vec_t v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 4))
            0: v = v & {$urandom(), $urandom()} & {$urandom(), $urandom()};
            1: v = v | {$urandom(), $urandom()};
            2: v = bmvc_pkg::vec_t'(1) << $urandom_range(0, n - 1);
            3: v = '0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_grid(input int unsigned n);
        for (int i = 0; i < n; i++) send_row(random_row(n));
        grids_sent++;
    endtask

    initial begin
        int unsigned n;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_row_cells = '0;
        quiet       = 0;
        hold_req    = 0;
        rows_sent   = 0;
        grids_sent  = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. A single empty cell gives the empty cover; a single
        // coin gives one row line.
        write_size(bmvc_pkg::cnt_t'(1));
        send_row('0);
        send_row('1);
        // A size of zero behaves as one.
        write_size(bmvc_pkg::cnt_t'(0));
        send_row(bmvc_pkg::vec_t'(1));
        // Identity and a lone full row; stray high bits must be ignored.
        write_size(bmvc_pkg::cnt_t'(2));
        send_row(bmvc_pkg::vec_t'(1));
        send_row(bmvc_pkg::vec_t'(2));
        send_row({62'h2aaa_5555_f0f0_1234, 2'b11});
        send_row({62'h3fff_ffff_ffff_ffff, 2'b00});
        write_size(bmvc_pkg::cnt_t'(3));
        send_row('1);
        send_row('1);
        send_row('1);
        grids_sent += 6;
        // Size change while loading: three rows go in at size eight, then
        // the size drops to two and the next row completes the grid using
        // only the first two rows.
        write_size(bmvc_pkg::cnt_t'(8));
        send_row(bmvc_pkg::vec_t'(3));
        send_row(bmvc_pkg::vec_t'(1));
        send_row(bmvc_pkg::vec_t'(6));
        write_size(bmvc_pkg::cnt_t'(2));
        send_row('1);
        grids_sent++;

        // Grids back to back at one size with the long receiver hold-off
        // armed: the sender keeps offering rows while the first results
        // wait, so the block stalls its input.
        write_size(bmvc_pkg::cnt_t'(5));
        hold_req = 1;
        for (int g = 0; g < 4; g++) send_grid(5);

        // Random small grids.
        while (rows_sent < 76) begin
            n = $urandom_range(1, 8);
            write_size(bmvc_pkg::cnt_t'(n));
            send_grid(n);
        end

        // Final full-size grid, written as a size above the maximum, with no
        // idling on either side.
        write_size(bmvc_pkg::cnt_t'(127));
        quiet = 1;
        send_grid(64);
        drain();

        $display("covered %0d grids from %0d rows and %0d result items,",
                 grids_sent, rows_sent, lines_seen);
        $display("sizes 0 to 127 written, stalls and a long output hold-off");
        if (fail_count == 0 && pending_count == 0) begin
            $display("bipartite_matching_vertex_cover verification clean");
        end else begin
            $display("bipartite_matching_vertex_cover verification failed");
        end
        $finish;
    end

endmodule

[bipartite_matching_vertex_cover.f]
rtl/core/bmvc_pkg.sv
rtl/core/bmvc_ram.sv
rtl/core/bmvc_ctrl.sv
rtl/core/bmvc_datapath.sv
rtl/core/bipartite_matching_vertex_cover.sv
verif/bmvc_checker.sv
verif/testbench.sv
